[rtl/des_rf_pkg.sv]
package des_rf_pkg;

  localparam int HalfW = 32;
  localparam int KeyW  = 48;
  localparam int NumBox = 8;

  typedef logic [HalfW-1:0] half_t;
  typedef logic [KeyW-1:0]  key_t;
  typedef logic [3:0]       nibble_t;
  typedef logic [5:0]       group_t;

  // positions count from 1 at the msb
  localparam logic [5:0] E_TAB [48] = '{
    6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,
    6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
    6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13,
    6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
    6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21,
    6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
    6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29,
    6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
  };

  localparam logic [5:0] P_TAB [32] = '{
    6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
    6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
    6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
    6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
  };

  localparam logic [3:0] S_TAB [8][4][16] = '{
    '{'{4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
        4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7},
      '{4'd0, 4'd15, 4'd7, 4'd4, 4'd14, 4'd2, 4'd13, 4'd1,
        4'd10, 4'd6, 4'd12, 4'd11, 4'd9, 4'd5, 4'd3, 4'd8},
      '{4'd4, 4'd1, 4'd14, 4'd8, 4'd13, 4'd6, 4'd2, 4'd11,
        4'd15, 4'd12, 4'd9, 4'd7, 4'd3, 4'd10, 4'd5, 4'd0},
      '{4'd15, 4'd12, 4'd8, 4'd2, 4'd4, 4'd9, 4'd1, 4'd7,
        4'd5, 4'd11, 4'd3, 4'd14, 4'd10, 4'd0, 4'd6, 4'd13}},
    '{'{4'd15, 4'd1, 4'd8, 4'd14, 4'd6, 4'd11, 4'd3, 4'd4,
        4'd9, 4'd7, 4'd2, 4'd13, 4'd12, 4'd0, 4'd5, 4'd10},
      '{4'd3, 4'd13, 4'd4, 4'd7, 4'd15, 4'd2, 4'd8, 4'd14,
        4'd12, 4'd0, 4'd1, 4'd10, 4'd6, 4'd9, 4'd11, 4'd5},
      '{4'd0, 4'd14, 4'd7, 4'd11, 4'd10, 4'd4, 4'd13, 4'd1,
        4'd5, 4'd8, 4'd12, 4'd6, 4'd9, 4'd3, 4'd2, 4'd15},
      '{4'd13, 4'd8, 4'd10, 4'd1, 4'd3, 4'd15, 4'd4, 4'd2,
        4'd11, 4'd6, 4'd7, 4'd12, 4'd0, 4'd5, 4'd14, 4'd9}},
    '{'{4'd10, 4'd0, 4'd9, 4'd14, 4'd6, 4'd3, 4'd15, 4'd5,
        4'd1, 4'd13, 4'd12, 4'd7, 4'd11, 4'd4, 4'd2, 4'd8},
      '{4'd13, 4'd7, 4'd0, 4'd9, 4'd3, 4'd4, 4'd6, 4'd10,
        4'd2, 4'd8, 4'd5, 4'd14, 4'd12, 4'd11, 4'd15, 4'd1},
      '{4'd13, 4'd6, 4'd4, 4'd9, 4'd8, 4'd15, 4'd3, 4'd0,
        4'd11, 4'd1, 4'd2, 4'd12, 4'd5, 4'd10, 4'd14, 4'd7},
      '{4'd1, 4'd10, 4'd13, 4'd0, 4'd6, 4'd9, 4'd8, 4'd7,
        4'd4, 4'd15, 4'd14, 4'd3, 4'd11, 4'd5, 4'd2, 4'd12}},
    '{'{4'd7, 4'd13, 4'd14, 4'd3, 4'd0, 4'd6, 4'd9, 4'd10,
        4'd1, 4'd2, 4'd8, 4'd5, 4'd11, 4'd12, 4'd4, 4'd15},
      '{4'd13, 4'd8, 4'd11, 4'd5, 4'd6, 4'd15, 4'd0, 4'd3,
        4'd4, 4'd7, 4'd2, 4'd12, 4'd1, 4'd10, 4'd14, 4'd9},
      '{4'd10, 4'd6, 4'd9, 4'd0, 4'd12, 4'd11, 4'd7, 4'd13,
        4'd15, 4'd1, 4'd3, 4'd14, 4'd5, 4'd2, 4'd8, 4'd4},
      '{4'd3, 4'd15, 4'd0, 4'd6, 4'd10, 4'd1, 4'd13, 4'd8,
        4'd9, 4'd4, 4'd5, 4'd11, 4'd12, 4'd7, 4'd2, 4'd14}},
    '{'{4'd2, 4'd12, 4'd4, 4'd1, 4'd7, 4'd10, 4'd11, 4'd6,
        4'd8, 4'd5, 4'd3, 4'd15, 4'd13, 4'd0, 4'd14, 4'd9},
      '{4'd14, 4'd11, 4'd2, 4'd12, 4'd4, 4'd7, 4'd13, 4'd1,
        4'd5, 4'd0, 4'd15, 4'd10, 4'd3, 4'd9, 4'd8, 4'd6},
      '{4'd4, 4'd2, 4'd1, 4'd11, 4'd10, 4'd13, 4'd7, 4'd8,
        4'd15, 4'd9, 4'd12, 4'd5, 4'd6, 4'd3, 4'd0, 4'd14},
      '{4'd11, 4'd8, 4'd12, 4'd7, 4'd1, 4'd14, 4'd2, 4'd13,
        4'd6, 4'd15, 4'd0, 4'd9, 4'd10, 4'd4, 4'd5, 4'd3}},
    '{'{4'd12, 4'd1, 4'd10, 4'd15, 4'd9, 4'd2, 4'd6, 4'd8,
        4'd0, 4'd13, 4'd3, 4'd4, 4'd14, 4'd7, 4'd5, 4'd11},
      '{4'd10, 4'd15, 4'd4, 4'd2, 4'd7, 4'd12, 4'd9, 4'd5,
        4'd6, 4'd1, 4'd13, 4'd14, 4'd0, 4'd11, 4'd3, 4'd8},
      '{4'd9, 4'd14, 4'd15, 4'd5, 4'd2, 4'd8, 4'd12, 4'd3,
        4'd7, 4'd0, 4'd4, 4'd10, 4'd1, 4'd13, 4'd11, 4'd6},
      '{4'd4, 4'd3, 4'd2, 4'd12, 4'd9, 4'd5, 4'd15, 4'd10,
        4'd11, 4'd14, 4'd1, 4'd7, 4'd6, 4'd0, 4'd8, 4'd13}},
    '{'{4'd4, 4'd11, 4'd2, 4'd14, 4'd15, 4'd0, 4'd8, 4'd13,
        4'd3, 4'd12, 4'd9, 4'd7, 4'd5, 4'd10, 4'd6, 4'd1},
      '{4'd13, 4'd0, 4'd11, 4'd7, 4'd4, 4'd9, 4'd1, 4'd10,
        4'd14, 4'd3, 4'd5, 4'd12, 4'd2, 4'd15, 4'd8, 4'd6},
      '{4'd1, 4'd4, 4'd11, 4'd13, 4'd12, 4'd3, 4'd7, 4'd14,
        4'd10, 4'd15, 4'd6, 4'd8, 4'd0, 4'd5, 4'd9, 4'd2},
      '{4'd6, 4'd11, 4'd13, 4'd8, 4'd1, 4'd4, 4'd10, 4'd7,
        4'd9, 4'd5, 4'd0, 4'd15, 4'd14, 4'd2, 4'd3, 4'd12}},
    '{'{4'd13, 4'd2, 4'd8, 4'd4, 4'd6, 4'd15, 4'd11, 4'd1,
        4'd10, 4'd9, 4'd3, 4'd14, 4'd5, 4'd0, 4'd12, 4'd7},
      '{4'd1, 4'd15, 4'd13, 4'd8, 4'd10, 4'd3, 4'd7, 4'd4,
        4'd12, 4'd5, 4'd6, 4'd11, 4'd0, 4'd14, 4'd9, 4'd2},
      '{4'd7, 4'd11, 4'd4, 4'd1, 4'd9, 4'd12, 4'd14, 4'd2,
        4'd0, 4'd6, 4'd10, 4'd13, 4'd15, 4'd3, 4'd5, 4'd8},
      '{4'd2, 4'd1, 4'd14, 4'd7, 4'd4, 4'd10, 4'd8, 4'd13,
        4'd15, 4'd12, 4'd9, 4'd0, 4'd3, 4'd5, 4'd6, 4'd11}}
  };

  function automatic key_t des_rf_expand(input half_t r);
    key_t e;
    int src;
    e = '0;
    for (int k = 0; k < KeyW; k++) begin
      src = HalfW - int'(E_TAB[k]);
      e[KeyW-1-k] = r[src[4:0]];
    end
    return e;
  endfunction

  function automatic half_t des_rf_permute(input half_t s);
    half_t p;
    int src;
    p = '0;
    for (int k = 0; k < HalfW; k++) begin
      src = HalfW - int'(P_TAB[k]);
      p[HalfW-1-k] = s[src[4:0]];
    end
    return p;
  endfunction

  // row from the outer bits, column from the middle four
  function automatic nibble_t des_rf_sbox(input int box, input group_t grp);
    return S_TAB[box][{grp[5], grp[0]}][grp[4:1]];
  endfunction

  function automatic half_t des_rf_f(input half_t r, input key_t k);
    key_t  x;
    half_t s;
    x = des_rf_expand(r) ^ k;
    s = '0;
    for (int g = 0; g < NumBox; g++) begin
      s[HalfW-1-4*g -: 4] = des_rf_sbox(g, x[KeyW-1-6*g -: 6]);
    end
    return des_rf_permute(s);
  endfunction

endpackage

[rtl/des_rf_f_unit.sv]
module des_rf_f_unit (
  input  des_rf_pkg::half_t right_half,
  input  des_rf_pkg::key_t  round_key,
  output des_rf_pkg::half_t f_result
);
  import des_rf_pkg::*;

  key_t  mixed;
  half_t subst;

  assign mixed = des_rf_expand(right_half) ^ round_key;

  for (genvar g = 0; g < NumBox; g++) begin : g_box
    assign subst[HalfW-1-4*g -: 4] = des_rf_sbox(g, mixed[KeyW-1-6*g -: 6]);
  end

  assign f_result = des_rf_permute(subst);

endmodule

[rtl/des_round_function_core.sv]
// channel   | handshake               | payload
// ----------+-------------------------+------------------------------
// input     | start, busy (always low)| in_right_half, in_round_key
// result    | out_valid strobe        | out_f_result
//
// one item per cycle; the result follows the transfer through the
// input register, then e/key xor/s-boxes/p, then result register
// reset clears both valid flags only; data registers are not reset
// the receiver cannot stall: each result stands for one cycle
module des_round_function_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  des_rf_pkg::half_t in_right_half,
  input  des_rf_pkg::key_t  in_round_key,
  output logic              out_valid,
  output des_rf_pkg::half_t out_f_result
);
  import des_rf_pkg::*;

  logic  in_vld_r;
  half_t half_r;
  key_t  key_r;
  logic  out_vld_r;
  half_t f_r;
  half_t f_nxt;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= start && !busy;
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      half_r <= in_right_half;
      key_r  <= in_round_key;
    end
    if (in_vld_r) begin
      f_r <= f_nxt;
    end
  end

  des_rf_f_unit u_f (
    .right_half (half_r),
    .round_key  (key_r),
    .f_result   (f_nxt)
  );

  assign out_valid    = out_vld_r;
  assign out_f_result = f_r;

  a_accept_flows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> in_vld_r)
    else $error("accepted transfer did not enter the input register");

  a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("result strobe missing two cycles after transfer");

  a_result_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_f_result == des_rf_f($past(in_right_half, 2), $past(in_round_key, 2)))
    else $error("result does not match the round function of its input");

endmodule
